FILE: src/mfe_pkg.sv
// Shared constants, codes and control/status types for the max-flow engine.
package mfe_pkg;

    localparam int NV = 16;
    localparam int NE = 64;
    localparam int VW = 4;
    localparam int FW = 22;
    localparam logic [FW-1:0] FLOW_MAX = 22'h3FFFFF;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_SOLVE = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    typedef struct packed {
        logic take;
        logic drop;
        logic add_rd;
        logic add_wr;
        logic clear;
        logic solve_init;
        logic search_init;
        logic pop;
        logic edge_rd;
        logic e_inc;
        logic rd_a;
        logic rd_b;
        logic visit_a;
        logic visit_b;
        logic aug_init;
        logic aug_rd1;
        logic aug_rd2;
        logic aug_wr;
        logic reach_init;
        logic pass_init;
        logic u_inc;
        logic v_init;
        logic reach_rd;
        logic reach_chk;
        logic busy_init;
        logic busy_step;
        logic emit_init;
        logic emit_load;
        logic emit_next;
    } cmd_t;

    typedef struct packed {
        logic add_bad;
        logic ok;
        logic q_more;
        logic e_more;
        logic ea_cur;
        logic eb_cur;
        logic hit_a;
        logic hit_b;
        logic walk_done;
        logic u_end;
        logic u_reach;
        logic v_end;
        logic changed;
        logic i_end;
        logic out_valid;
        logic out_last;
    } sts_t;

    function automatic logic [FW-1:0] sat_add(input logic [FW-1:0] a, input logic [FW-1:0] b);
        logic [FW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[FW] ? FLOW_MAX : s[FW-1:0];
    endfunction

endpackage

FILE: src/max_flow_min_cut_engine.sv
// Max-flow / min-cut engine top level: controller, datapath and checks.
// Input beats are taken one at a time; an edge add is dropped when a vertex is out of range or
// the edge list is full. A solve with a valid source and sink runs breadth-first searches over
// the arrival-ordered edge list through the residual memory, which has a single write port;
// each found path is walked back from the sink to augment it. Min-cut marking then runs one
// pass per growth of the cut side, plus a final one, followed by the busiest-vertex scan and
// the result beats (n beats, the last flagged), which wait out any output stall.
module max_flow_min_cut_engine (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [4:0]              vertex_count,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [1:0]              op,
    input  logic [4:0]              edge_from,
    input  logic [4:0]              edge_to,
    input  logic [15:0]             edge_cap,
    input  logic [4:0]              source_vertex,
    input  logic [4:0]              sink_vertex,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [4:0]              vertex_id,
    output logic                    on_source_side,
    output logic [mfe_pkg::FW-1:0]  vertex_flow,
    output logic [mfe_pkg::FW-1:0]  total_flow,
    output logic [4:0]              busiest_vertex,
    output logic [mfe_pkg::FW-1:0]  busiest_flow,
    output logic                    edge_overflow,
    output logic                    last
);

    mfe_pkg::cmd_t cmd;
    mfe_pkg::sts_t sts;

    assign cfg_ready = 1'b1;
    assign out_valid = sts.out_valid;

    mfe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .op        (op),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd),
        .in_ready  (in_ready)
    );

    mfe_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .vertex_count   (vertex_count),
        .edge_from      (edge_from),
        .edge_to        (edge_to),
        .edge_cap       (edge_cap),
        .source_vertex  (source_vertex),
        .sink_vertex    (sink_vertex),
        .cmd            (cmd),
        .sts            (sts),
        .out_ready      (out_ready),
        .vertex_id      (vertex_id),
        .on_source_side (on_source_side),
        .vertex_flow    (vertex_flow),
        .total_flow     (total_flow),
        .busiest_vertex (busiest_vertex),
        .busiest_flow   (busiest_flow),
        .edge_overflow  (edge_overflow),
        .last           (last)
    );

    a_no_accept_while_emitting: assert property (@(posedge clk) disable iff (!rst_n)
        !(out_valid && in_ready))
        else $error("input accepted while a result beat is pending");

    a_single_write_port: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.add_wr, cmd.aug_rd2, cmd.aug_wr}))
        else $error("two residual writes in one cycle");

    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last) |=> in_ready)
        else $error("not idle after final result beat");

endmodule

FILE: src/mfe_datapath.sv
// Datapath: residual and edge memories, search queue, flow totals, result register.
module mfe_datapath (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    input  logic [4:0]              vertex_count,
    input  logic [4:0]              edge_from,
    input  logic [4:0]              edge_to,
    input  logic [15:0]             edge_cap,
    input  logic [4:0]              source_vertex,
    input  logic [4:0]              sink_vertex,
    input  mfe_pkg::cmd_t           cmd,
    output mfe_pkg::sts_t           sts,
    input  logic                    out_ready,
    output logic [4:0]              vertex_id,
    output logic                    on_source_side,
    output logic [mfe_pkg::FW-1:0]  vertex_flow,
    output logic [mfe_pkg::FW-1:0]  total_flow,
    output logic [4:0]              busiest_vertex,
    output logic [mfe_pkg::FW-1:0]  busiest_flow,
    output logic                    edge_overflow,
    output logic                    last
);

    localparam int NV = mfe_pkg::NV;
    localparam int NE = mfe_pkg::NE;
    localparam int VW = mfe_pkg::VW;
    localparam int FW = mfe_pkg::FW;

    logic [4:0]      vcount_reg;
    logic [4:0]      a_reg, b_reg, s_reg, t_reg;
    logic [15:0]     c_reg;
    logic [4:0]      n;
    logic [VW-1:0]   a0, b0, src, sink;

    logic [FW-1:0]   cap_mem [0:NV*NV-1];
    logic [NV*NV-1:0] cap_vld_reg;
    logic [FW-1:0]   cap_rd_reg;
    logic            cap_rd_vld_reg;
    logic [FW-1:0]   capval;
    logic [2*VW-1:0] rd_addr, wr_addr;
    logic            wr_en;
    logic [FW-1:0]   wr_data;

    logic [2*VW-1:0] edge_mem [0:NE-1];
    logic [2*VW-1:0] edge_rd_reg;
    logic [6:0]      et_reg, e_reg;
    logic [VW-1:0]   ea, eb;

    logic [VW-1:0]   qv_mem [0:NV-1];
    logic [FW-1:0]   qf_mem [0:NV-1];
    logic [VW-1:0]   parent_mem [0:NV-1];
    logic [4:0]      head_reg, qlen_reg;
    logic [NV-1:0]   seen_reg, reach_reg;
    logic [VW-1:0]   cur_reg, walk_reg, prev;
    logic [FW-1:0]   f_reg, aug_f_reg, total_reg;
    logic [FW-1:0]   inflow_reg [0:NV-1];
    logic [VW-1:0]   inflow_idx;
    logic [FW-1:0]   inflow_rd;
    logic [4:0]      u_reg, v_reg, i_reg, bv_reg;
    logic            changed_reg, found_reg, drop_reg;
    logic [FW-1:0]   bf_reg;

    logic            ok_a, ok_b, vis_ok, is_term;
    logic [VW-1:0]   vis_nb;
    logic [FW-1:0]   nf;
    logic [4:0]      i_next;

    logic            out_valid_reg;

    always_comb
    begin
        if (vcount_reg == 5'd0)
            n = 5'd1;
        else if (vcount_reg > 5'(NV))
            n = 5'(NV);
        else
            n = vcount_reg;
    end

    assign a0   = VW'(a_reg - 5'd1);
    assign b0   = VW'(b_reg - 5'd1);
    assign src  = VW'(s_reg - 5'd1);
    assign sink = VW'(t_reg - 5'd1);
    assign ea   = edge_rd_reg[2*VW-1:VW];
    assign eb   = edge_rd_reg[VW-1:0];
    assign prev = parent_mem[walk_reg];
    assign capval = cap_rd_vld_reg ? cap_rd_reg : '0;
    assign nf   = (capval < f_reg) ? capval : f_reg;
    assign i_next = i_reg + 5'd1;

    assign ok_a = ({1'b0, eb} < n) && !seen_reg[eb] && (capval != '0);
    assign ok_b = ({1'b0, ea} < n) && !seen_reg[ea] && (capval != '0);
    assign vis_nb = cmd.visit_a ? eb : ea;
    assign vis_ok = (cmd.visit_a && ok_a) || (cmd.visit_b && ok_b);

    assign inflow_idx = (cmd.busy_step || cmd.emit_load) ? i_reg[VW-1:0] : walk_reg;
    assign inflow_rd  = inflow_reg[inflow_idx];
    assign is_term    = (i_next == s_reg) || (i_next == t_reg);

    // residual memory address and write selection
    always_comb
    begin
        rd_addr = {cur_reg, eb};
        if (cmd.add_rd)
            rd_addr = {a0, b0};
        else if (cmd.rd_a)
            rd_addr = {cur_reg, eb};
        else if (cmd.rd_b)
            rd_addr = {cur_reg, ea};
        else if (cmd.aug_rd1)
            rd_addr = {prev, walk_reg};
        else if (cmd.aug_rd2)
            rd_addr = {walk_reg, prev};
        else if (cmd.reach_rd)
            rd_addr = {u_reg[VW-1:0], v_reg[VW-1:0]};

        wr_en   = cmd.add_wr || cmd.aug_rd2 || cmd.aug_wr;
        wr_addr = {walk_reg, prev};
        wr_data = mfe_pkg::sat_add(capval, aug_f_reg);
        if (cmd.add_wr)
        begin
            wr_addr = {a0, b0};
            wr_data = mfe_pkg::sat_add(capval, FW'(c_reg));
        end
        else if (cmd.aug_rd2)
        begin
            wr_addr = {prev, walk_reg};
            wr_data = capval - aug_f_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            cap_mem[wr_addr] <= wr_data;
        cap_rd_reg <= cap_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.add_wr)
            edge_mem[et_reg[5:0]] <= {a0, b0};
        if (cmd.edge_rd)
            edge_rd_reg <= edge_mem[e_reg[5:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.search_init)
        begin
            qv_mem[0] <= src;
            qf_mem[0] <= mfe_pkg::FLOW_MAX;
        end
        else if (vis_ok && vis_nb != sink && qlen_reg < 5'(NV))
        begin
            qv_mem[qlen_reg[VW-1:0]] <= vis_nb;
            qf_mem[qlen_reg[VW-1:0]] <= nf;
        end
        if (vis_ok)
            parent_mem[vis_nb] <= cur_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg     <= 5'd16;
            a_reg          <= '0;
            b_reg          <= '0;
            c_reg          <= '0;
            s_reg          <= '0;
            t_reg          <= '0;
            cap_vld_reg    <= '0;
            cap_rd_vld_reg <= 1'b0;
            et_reg         <= '0;
            e_reg          <= '0;
            head_reg       <= '0;
            qlen_reg       <= '0;
            seen_reg       <= '0;
            reach_reg      <= '0;
            cur_reg        <= '0;
            walk_reg       <= '0;
            f_reg          <= '0;
            aug_f_reg      <= '0;
            total_reg      <= '0;
            for (int k = 0; k < NV; k++)
                inflow_reg[k] <= '0;
            u_reg          <= '0;
            v_reg          <= '0;
            i_reg          <= '0;
            bv_reg         <= '0;
            bf_reg         <= '0;
            changed_reg    <= 1'b0;
            found_reg      <= 1'b0;
            drop_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            vertex_id      <= '0;
            on_source_side <= 1'b0;
            vertex_flow    <= '0;
            total_flow     <= '0;
            busiest_vertex <= '0;
            busiest_flow   <= '0;
            edge_overflow  <= 1'b0;
            last           <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                vcount_reg <= vertex_count;
            if (cmd.take)
            begin
                a_reg  <= edge_from;
                b_reg  <= edge_to;
                c_reg  <= edge_cap;
                s_reg  <= source_vertex;
                t_reg  <= sink_vertex;
            end
            cap_rd_vld_reg <= cap_vld_reg[rd_addr];
            if (cmd.clear)
                cap_vld_reg <= '0;
            else if (wr_en)
                cap_vld_reg[wr_addr] <= 1'b1;
            if (cmd.drop)
                drop_reg <= 1'b1;
            if (cmd.clear)
            begin
                drop_reg  <= 1'b0;
                et_reg    <= '0;
                reach_reg <= '0;
                for (int k = 0; k < NV; k++)
                    inflow_reg[k] <= '0;
            end
            if (cmd.add_wr)
                et_reg <= et_reg + 7'd1;

            if (cmd.solve_init)
            begin
                reach_reg <= '0;
                total_reg <= '0;
            end
            if (cmd.search_init)
            begin
                seen_reg <= {{(NV-1){1'b0}}, 1'b1} << src;
                qlen_reg <= 5'd1;
                head_reg <= '0;
            end
            if (cmd.pop)
            begin
                cur_reg  <= qv_mem[head_reg[VW-1:0]];
                f_reg    <= qf_mem[head_reg[VW-1:0]];
                head_reg <= head_reg + 5'd1;
                e_reg    <= '0;
            end
            if (cmd.e_inc)
                e_reg <= e_reg + 7'd1;
            if (vis_ok)
            begin
                seen_reg[vis_nb] <= 1'b1;
                if (vis_nb == sink)
                    aug_f_reg <= nf;
                else if (qlen_reg < 5'(NV))
                    qlen_reg <= qlen_reg + 5'd1;
            end

            if (cmd.aug_init)
            begin
                total_reg <= mfe_pkg::sat_add(total_reg, aug_f_reg);
                walk_reg  <= sink;
            end
            if (cmd.aug_wr)
            begin
                inflow_reg[walk_reg] <= mfe_pkg::sat_add(inflow_rd, aug_f_reg);
                walk_reg <= prev;
            end

            if (cmd.reach_init)
                reach_reg[src] <= 1'b1;
            if (cmd.pass_init)
            begin
                changed_reg <= 1'b0;
                u_reg       <= '0;
            end
            if (cmd.u_inc)
                u_reg <= u_reg + 5'd1;
            if (cmd.v_init)
                v_reg <= '0;
            if (cmd.reach_chk)
            begin
                if (!reach_reg[v_reg[VW-1:0]] && capval != '0)
                begin
                    reach_reg[v_reg[VW-1:0]] <= 1'b1;
                    changed_reg <= 1'b1;
                end
                v_reg <= v_reg + 5'd1;
            end

            if (cmd.busy_init)
            begin
                i_reg     <= '0;
                found_reg <= 1'b0;
                bv_reg    <= '0;
                bf_reg    <= '0;
            end
            if (cmd.busy_step)
            begin
                if (!is_term && (!found_reg || bf_reg <= inflow_rd))
                begin
                    bf_reg    <= inflow_rd;
                    bv_reg    <= i_next;
                    found_reg <= 1'b1;
                end
                i_reg <= i_next;
            end
            if (cmd.emit_init)
                i_reg <= '0;
            if (cmd.emit_next)
                i_reg <= i_next;

            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            if (cmd.emit_load)
            begin
                out_valid_reg  <= 1'b1;
                vertex_id      <= i_next;
                on_source_side <= reach_reg[i_reg[VW-1:0]];
                vertex_flow    <= inflow_rd;
                total_flow     <= total_reg;
                busiest_vertex <= bv_reg;
                busiest_flow   <= bf_reg;
                edge_overflow  <= drop_reg;
                last           <= (i_next == n);
            end
        end
    end

    always_comb
    begin
        sts.add_bad   = (a_reg == 5'd0) || (a_reg > n) || (b_reg == 5'd0) || (b_reg > n)
                        || (et_reg >= 7'(NE));
        sts.ok        = (s_reg != 5'd0) && (s_reg <= n) && (t_reg != 5'd0) && (t_reg <= n);
        sts.q_more    = head_reg < qlen_reg;
        sts.e_more    = e_reg < et_reg;
        sts.ea_cur    = ea == cur_reg;
        sts.eb_cur    = eb == cur_reg;
        sts.hit_a     = ok_a && (eb == sink);
        sts.hit_b     = ok_b && (ea == sink);
        sts.walk_done = prev == src;
        sts.u_end     = u_reg >= n;
        sts.u_reach   = reach_reg[u_reg[VW-1:0]];
        sts.v_end     = v_reg >= n;
        sts.changed   = changed_reg;
        sts.i_end     = i_reg >= n;
        sts.out_valid = out_valid_reg;
        sts.out_last  = last;
    end

endmodule

FILE: src/mfe_ctrl.sv
// Controller: sequences edge loads, clears, augmenting searches, min-cut marking and result beats.
module mfe_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [1:0]    op,
    input  logic          out_ready,
    input  mfe_pkg::sts_t sts,
    output mfe_pkg::cmd_t cmd,
    output logic          in_ready
);

    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_ADD_RD = 5'd1;
    localparam logic [4:0] ST_ADD_WR = 5'd2;
    localparam logic [4:0] ST_CLEAR  = 5'd3;
    localparam logic [4:0] ST_SOLVE  = 5'd4;
    localparam logic [4:0] ST_START  = 5'd5;
    localparam logic [4:0] ST_POP    = 5'd6;
    localparam logic [4:0] ST_ERD    = 5'd7;
    localparam logic [4:0] ST_EDGE   = 5'd8;
    localparam logic [4:0] ST_VA     = 5'd9;
    localparam logic [4:0] ST_VB     = 5'd10;
    localparam logic [4:0] ST_A_INIT = 5'd11;
    localparam logic [4:0] ST_A_RD1  = 5'd12;
    localparam logic [4:0] ST_A_RD2  = 5'd13;
    localparam logic [4:0] ST_A_WR   = 5'd14;
    localparam logic [4:0] ST_R_INIT = 5'd15;
    localparam logic [4:0] ST_R_PASS = 5'd16;
    localparam logic [4:0] ST_R_U    = 5'd17;
    localparam logic [4:0] ST_R_V    = 5'd18;
    localparam logic [4:0] ST_R_CHK  = 5'd19;
    localparam logic [4:0] ST_B_INIT = 5'd20;
    localparam logic [4:0] ST_B_STEP = 5'd21;
    localparam logic [4:0] ST_E_LOAD = 5'd22;
    localparam logic [4:0] ST_E_WAIT = 5'd23;

    logic [4:0] state_reg, state_next;

    assign in_ready = state_reg == ST_IDLE;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take = 1'b1;
                    case (op)
                        mfe_pkg::OP_ADD:   state_next = ST_ADD_RD;
                        mfe_pkg::OP_SOLVE: state_next = ST_SOLVE;
                        mfe_pkg::OP_CLEAR: state_next = ST_CLEAR;
                        default:           state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ADD_RD:
            begin
                if (sts.add_bad)
                begin
                    cmd.drop   = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.add_rd = 1'b1;
                    state_next = ST_ADD_WR;
                end
            end
            ST_ADD_WR:
            begin
                cmd.add_wr = 1'b1;
                state_next = ST_IDLE;
            end
            ST_CLEAR:
            begin
                cmd.clear  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SOLVE:
            begin
                cmd.solve_init = 1'b1;
                state_next     = sts.ok ? ST_START : ST_B_INIT;
            end
            ST_START:
            begin
                cmd.search_init = 1'b1;
                state_next      = ST_POP;
            end
            ST_POP:
            begin
                if (sts.q_more)
                begin
                    cmd.pop    = 1'b1;
                    state_next = ST_ERD;
                end
                else
                    state_next = ST_R_INIT;
            end
            ST_ERD:
            begin
                if (sts.e_more)
                begin
                    cmd.edge_rd = 1'b1;
                    state_next  = ST_EDGE;
                end
                else
                    state_next = ST_POP;
            end
            ST_EDGE:
            begin
                if (sts.ea_cur)
                begin
                    cmd.rd_a   = 1'b1;
                    state_next = ST_VA;
                end
                else if (sts.eb_cur)
                begin
                    cmd.rd_b   = 1'b1;
                    state_next = ST_VB;
                end
                else
                begin
                    cmd.e_inc  = 1'b1;
                    state_next = ST_ERD;
                end
            end
            ST_VA:
            begin
                cmd.visit_a = 1'b1;
                if (sts.hit_a)
                    state_next = ST_A_INIT;
                else if (sts.eb_cur)
                begin
                    cmd.rd_b   = 1'b1;
                    state_next = ST_VB;
                end
                else
                begin
                    cmd.e_inc  = 1'b1;
                    state_next = ST_ERD;
                end
            end
            ST_VB:
            begin
                cmd.visit_b = 1'b1;
                if (sts.hit_b)
                    state_next = ST_A_INIT;
                else
                begin
                    cmd.e_inc  = 1'b1;
                    state_next = ST_ERD;
                end
            end
            ST_A_INIT:
            begin
                cmd.aug_init = 1'b1;
                state_next   = ST_A_RD1;
            end
            ST_A_RD1:
            begin
                cmd.aug_rd1 = 1'b1;
                state_next  = ST_A_RD2;
            end
            ST_A_RD2:
            begin
                cmd.aug_rd2 = 1'b1;
                state_next  = ST_A_WR;
            end
            ST_A_WR:
            begin
                cmd.aug_wr = 1'b1;
                state_next = sts.walk_done ? ST_START : ST_A_RD1;
            end
            ST_R_INIT:
            begin
                cmd.reach_init = 1'b1;
                state_next     = ST_R_PASS;
            end
            ST_R_PASS:
            begin
                cmd.pass_init = 1'b1;
                state_next    = ST_R_U;
            end
            ST_R_U:
            begin
                if (sts.u_end)
                    state_next = sts.changed ? ST_R_PASS : ST_B_INIT;
                else if (!sts.u_reach)
                    cmd.u_inc = 1'b1;
                else
                begin
                    cmd.v_init = 1'b1;
                    state_next = ST_R_V;
                end
            end
            ST_R_V:
            begin
                if (sts.v_end)
                begin
                    cmd.u_inc  = 1'b1;
                    state_next = ST_R_U;
                end
                else
                begin
                    cmd.reach_rd = 1'b1;
                    state_next   = ST_R_CHK;
                end
            end
            ST_R_CHK:
            begin
                cmd.reach_chk = 1'b1;
                state_next    = ST_R_V;
            end
            ST_B_INIT:
            begin
                cmd.busy_init = 1'b1;
                state_next    = ST_B_STEP;
            end
            ST_B_STEP:
            begin
                if (sts.i_end)
                begin
                    cmd.emit_init = 1'b1;
                    state_next    = ST_E_LOAD;
                end
                else
                    cmd.busy_step = 1'b1;
            end
            ST_E_LOAD:
            begin
                cmd.emit_load = 1'b1;
                state_next    = ST_E_WAIT;
            end
            ST_E_WAIT:
            begin
                if (sts.out_valid && out_ready)
                begin
                    if (sts.out_last)
                        state_next = ST_IDLE;
                    else
                    begin
                        cmd.emit_next = 1'b1;
                        state_next    = ST_E_LOAD;
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule
